// File: design/cotok_pkg.sv
package cotok_pkg;

    localparam int KIND_BITS  = 6;
    localparam int VALUE_BITS = 64;
    localparam int FIFO_DEPTH = 4;

    // Token kinds, in source order
    localparam logic [KIND_BITS-1:0] K_UNKNOWN   = 6'd0;
    localparam logic [KIND_BITS-1:0] K_EOS       = 6'd1;
    localparam logic [KIND_BITS-1:0] K_LPAREN    = 6'd2;
    localparam logic [KIND_BITS-1:0] K_RPAREN    = 6'd3;
    localparam logic [KIND_BITS-1:0] K_LBRACKET  = 6'd4;
    localparam logic [KIND_BITS-1:0] K_RBRACKET  = 6'd5;
    localparam logic [KIND_BITS-1:0] K_LBRACE    = 6'd6;
    localparam logic [KIND_BITS-1:0] K_RBRACE    = 6'd7;
    localparam logic [KIND_BITS-1:0] K_COMMA     = 6'd8;
    localparam logic [KIND_BITS-1:0] K_DOT       = 6'd9;
    localparam logic [KIND_BITS-1:0] K_SQUOTE    = 6'd10;
    localparam logic [KIND_BITS-1:0] K_DQUOTE    = 6'd11;
    localparam logic [KIND_BITS-1:0] K_SEMI      = 6'd12;
    localparam logic [KIND_BITS-1:0] K_COLON     = 6'd13;
    localparam logic [KIND_BITS-1:0] K_PLUS      = 6'd14;
    localparam logic [KIND_BITS-1:0] K_MINUS     = 6'd15;
    localparam logic [KIND_BITS-1:0] K_STAR      = 6'd16;
    localparam logic [KIND_BITS-1:0] K_SLASH     = 6'd17;
    localparam logic [KIND_BITS-1:0] K_PERCENT   = 6'd18;
    localparam logic [KIND_BITS-1:0] K_INC       = 6'd19;
    localparam logic [KIND_BITS-1:0] K_DEC       = 6'd20;
    localparam logic [KIND_BITS-1:0] K_GT        = 6'd21;
    localparam logic [KIND_BITS-1:0] K_LT        = 6'd22;
    localparam logic [KIND_BITS-1:0] K_EQEQ      = 6'd23;
    localparam logic [KIND_BITS-1:0] K_GE        = 6'd24;
    localparam logic [KIND_BITS-1:0] K_LE        = 6'd25;
    localparam logic [KIND_BITS-1:0] K_NE        = 6'd26;
    localparam logic [KIND_BITS-1:0] K_ANDAND    = 6'd27;
    localparam logic [KIND_BITS-1:0] K_OROR      = 6'd28;
    localparam logic [KIND_BITS-1:0] K_NOT       = 6'd29;
    localparam logic [KIND_BITS-1:0] K_ASSIGN    = 6'd30;
    localparam logic [KIND_BITS-1:0] K_PLUS_EQ   = 6'd31;
    localparam logic [KIND_BITS-1:0] K_MINUS_EQ  = 6'd32;
    localparam logic [KIND_BITS-1:0] K_STAR_EQ   = 6'd33;
    localparam logic [KIND_BITS-1:0] K_SLASH_EQ  = 6'd34;
    localparam logic [KIND_BITS-1:0] K_PERCENT_EQ = 6'd35;
    localparam logic [KIND_BITS-1:0] K_SHL       = 6'd36;
    localparam logic [KIND_BITS-1:0] K_SHR       = 6'd37;
    localparam logic [KIND_BITS-1:0] K_AMP       = 6'd38;
    localparam logic [KIND_BITS-1:0] K_PIPE      = 6'd39;
    localparam logic [KIND_BITS-1:0] K_CARET     = 6'd40;
    localparam logic [KIND_BITS-1:0] K_INT       = 6'd41;
    localparam logic [KIND_BITS-1:0] K_IDENT     = 6'd42;
    localparam logic [KIND_BITS-1:0] K_BACKSLASH = 6'd43;

    localparam logic [7:0] CH_END        = 8'h00;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_ZERO       = "0";
    localparam logic [7:0] CH_UNDERSCORE = "_";
    localparam logic [7:0] CH_EQUAL      = "=";
    localparam logic [7:0] CH_AMP        = "&";
    localparam logic [7:0] CH_PIPE       = "|";

    // Lexer mode, one-hot
    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_OP    = 4'b0010,
        MODE_IDENT = 4'b0100,
        MODE_NUM   = 4'b1000
    } t_mode;

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0D, 8'h0B, 8'h0C};
    endfunction

    // Complete one-character tokens; K_UNKNOWN if not one
    function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] c);
        case (c)
            "(":     return K_LPAREN;
            ")":     return K_RPAREN;
            "[":     return K_LBRACKET;
            "]":     return K_RBRACKET;
            "{":     return K_LBRACE;
            "}":     return K_RBRACE;
            ",":     return K_COMMA;
            ".":     return K_DOT;
            "'":     return K_SQUOTE;
            "\"":    return K_DQUOTE;
            ";":     return K_SEMI;
            ":":     return K_COLON;
            "^":     return K_CARET;
            "\\":    return K_BACKSLASH;
            default: return K_UNKNOWN;
        endcase
    endfunction

    // Operator start characters standing alone; K_UNKNOWN if not one
    function automatic logic [KIND_BITS-1:0] op_alone(input logic [7:0] c);
        case (c)
            "+":       return K_PLUS;
            "-":       return K_MINUS;
            "*":       return K_STAR;
            "/":       return K_SLASH;
            "%":       return K_PERCENT;
            ">":       return K_GT;
            "<":       return K_LT;
            "!":       return K_NOT;
            CH_EQUAL:  return K_ASSIGN;
            CH_AMP:    return K_AMP;
            CH_PIPE:   return K_PIPE;
            default:   return K_UNKNOWN;
        endcase
    endfunction

    // Two-character operator c,b; K_UNKNOWN if they do not pair
    function automatic logic [KIND_BITS-1:0] op_pair(input logic [7:0] c, input logic [7:0] b);
        case (c)
            "*":      return (b == CH_EQUAL) ? K_STAR_EQ : K_UNKNOWN;
            "/":      return (b == CH_EQUAL) ? K_SLASH_EQ : K_UNKNOWN;
            "%":      return (b == CH_EQUAL) ? K_PERCENT_EQ : K_UNKNOWN;
            CH_EQUAL: return (b == CH_EQUAL) ? K_EQEQ : K_UNKNOWN;
            "!":      return (b == CH_EQUAL) ? K_NE : K_UNKNOWN;
            CH_AMP:   return (b == CH_AMP) ? K_ANDAND : K_UNKNOWN;
            CH_PIPE:  return (b == CH_PIPE) ? K_OROR : K_UNKNOWN;
            "+":      return (b == "+") ? K_INC : ((b == CH_EQUAL) ? K_PLUS_EQ : K_UNKNOWN);
            "-":      return (b == "-") ? K_DEC : ((b == CH_EQUAL) ? K_MINUS_EQ : K_UNKNOWN);
            ">":      return (b == ">") ? K_SHR : ((b == CH_EQUAL) ? K_GE : K_UNKNOWN);
            "<":      return (b == "<") ? K_SHL : ((b == CH_EQUAL) ? K_LE : K_UNKNOWN);
            default:  return K_UNKNOWN;
        endcase
    endfunction

endpackage

// File: design/c_style_operator_tokenizer.sv
// C-style operator tokenizer.
// Slave stream (i_s_*): one source byte per word in i_s_tdata[7:0]; byte 0
// ends the stream. Master stream (o_m_*): one token per word.
//   o_m_tuser = token kind (0 unknown, 1 end of stream, ... 43 backslash).
//   o_m_tdata = line, offset, length, integer value, overflow flag, packed
//               from bit 0 up and zero padded to whole bytes.
//   o_m_tlast = last token caused by the accepted byte.
// A byte yields zero, one or two tokens. Tokens are built in the same cycle
// the byte is accepted and written into a 4-word output queue, whose head
// drives o_m_* (an operator or a word is seen only when the byte after it
// arrives). A byte is taken whenever the queue has room for two tokens,
// i.e. up to two tokens may already wait there: one byte per cycle
// sustained while the sink keeps up, and the queue is what parts the two
// sides when the sink stalls. Bytes that emit two tokens leave two words
// for the sink, one per handshake, which bounds the rate at the output port.
// Reset (i_rst_n low, synchronous) empties the queue and returns the lexer
// to line 1, offset 0. Byte 0 does the same to the lexer after it has
// flushed any pending token and queued the end-of-stream token.
module c_style_operator_tokenizer #(
    parameter int POSITION_BITS = 32,
    parameter int LINE_BITS     = 24,
    parameter int LENGTH_BITS   = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // slave stream
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [7:0]                            i_s_tdata,  // text_byte
    // master stream
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // token_line, token_offset, token_length, int_value, int_overflow, zero pad
    output logic [((LINE_BITS + POSITION_BITS + LENGTH_BITS
                    + cotok_pkg::VALUE_BITS + 8) / 8) * 8 - 1:0] o_m_tdata,
    output logic [cotok_pkg::KIND_BITS-1:0]       o_m_tuser,  // token_kind
    output logic                                  o_m_tlast   // last_of_run
);

    localparam int PAYLOAD_BITS = LINE_BITS + POSITION_BITS + LENGTH_BITS
                                + cotok_pkg::VALUE_BITS + 1;
    localparam int DATA_BITS    = ((PAYLOAD_BITS + 7) / 8) * 8;
    localparam int WIDE_BITS    = (POSITION_BITS > LENGTH_BITS) ? POSITION_BITS : LENGTH_BITS;
    localparam int PTR_BITS     = $clog2(cotok_pkg::FIFO_DEPTH);
    localparam int CNT_BITS     = $clog2(cotok_pkg::FIFO_DEPTH + 1);
    localparam int ACC_BITS     = cotok_pkg::VALUE_BITS + 4;

    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};
    localparam logic [CNT_BITS-1:0]    ROOM_MAX = CNT_BITS'(cotok_pkg::FIFO_DEPTH - 2);

    typedef struct packed {
        logic                                ovf;
        logic [cotok_pkg::VALUE_BITS-1:0]    value;
        logic [LENGTH_BITS-1:0]              len;
        logic [POSITION_BITS-1:0]            off;
        logic [LINE_BITS-1:0]                line;
        logic [cotok_pkg::KIND_BITS-1:0]     kind;
        logic                                last;
    } t_token;

    // lexer state
    cotok_pkg::t_mode                  r_mode, n_mode;
    logic [7:0]                        r_pend, n_pend;
    logic [LINE_BITS-1:0]              r_line, n_line;
    logic [POSITION_BITS-1:0]          r_pos, n_pos;
    logic [POSITION_BITS-1:0]          r_start_pos, n_start_pos;
    logic [LINE_BITS-1:0]              r_start_line, n_start_line;
    logic [cotok_pkg::VALUE_BITS-1:0]  r_accum, n_accum;
    logic                              r_ovf, n_ovf;

    // output queue
    t_token                            r_fifo [cotok_pkg::FIFO_DEPTH];
    logic [PTR_BITS-1:0]               r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0]               r_count;

    logic                              in_acc, out_acc;
    logic [7:0]                        b;
    logic                              consumed;
    logic                              e0_v, e1_v;
    t_token                            e0, e1;
    logic [cotok_pkg::KIND_BITS-1:0]   pair_kind;
    logic [POSITION_BITS-1:0]          run;
    logic [WIDE_BITS-1:0]              run_w;
    logic [LENGTH_BITS-1:0]            run_len;
    logic [ACC_BITS-1:0]               digit_w, acc_next;
    logic                              acc_over;
    logic [1:0]                        wr_n;
    t_token                            head;

    assign b       = i_s_tdata;
    assign in_acc  = i_s_tvalid && o_s_tready;
    assign out_acc = o_m_tvalid && i_m_tready;

    assign pair_kind = cotok_pkg::op_pair(r_pend, b);
    assign run       = r_pos - r_start_pos;
    assign run_w     = WIDE_BITS'(run);
    assign run_len   = (run_w > WIDE_BITS'(LEN_MAX)) ? LEN_MAX : LENGTH_BITS'(run_w);

    // accum * 10 + digit by shift-add; any carry above 64 bits is overflow
    assign digit_w  = ACC_BITS'(b - cotok_pkg::CH_ZERO);
    assign acc_next = (ACC_BITS'(r_accum) << 3) + (ACC_BITS'(r_accum) << 1) + digit_w;
    assign acc_over = r_ovf || (acc_next[ACC_BITS-1:cotok_pkg::VALUE_BITS] != '0);

    always_comb begin
        n_mode       = r_mode;
        n_pend       = r_pend;
        n_line       = r_line;
        n_pos        = r_pos + POSITION_BITS'(1);
        n_start_pos  = r_start_pos;
        n_start_line = r_start_line;
        n_accum      = r_accum;
        n_ovf        = r_ovf;
        consumed     = 1'b0;
        e0_v         = 1'b0;
        e1_v         = 1'b0;
        e0           = '0;
        e1           = '0;
        e0.line      = r_start_line;
        e0.off       = r_start_pos;
        e1.line      = r_line;
        e1.off       = r_pos;
        e1.len       = LENGTH_BITS'(1);

        // close or extend the open token
        case (r_mode)
            cotok_pkg::MODE_OP: begin
                e0_v   = 1'b1;
                n_mode = cotok_pkg::MODE_IDLE;
                if (pair_kind != cotok_pkg::K_UNKNOWN) begin
                    e0.kind  = pair_kind;
                    e0.len   = LENGTH_BITS'(2);
                    consumed = 1'b1;
                end else begin
                    e0.kind = cotok_pkg::op_alone(r_pend);
                    e0.len  = LENGTH_BITS'(1);
                end
            end
            cotok_pkg::MODE_IDENT: begin
                if (cotok_pkg::is_alpha(b) || cotok_pkg::is_digit(b)
                        || b == cotok_pkg::CH_UNDERSCORE) begin
                    consumed = 1'b1;
                end else begin
                    e0_v    = 1'b1;
                    e0.kind = cotok_pkg::K_IDENT;
                    e0.len  = run_len;
                    n_mode  = cotok_pkg::MODE_IDLE;
                end
            end
            cotok_pkg::MODE_NUM: begin
                if (cotok_pkg::is_digit(b)) begin
                    consumed = 1'b1;
                    n_ovf    = acc_over;
                    n_accum  = acc_over ? {cotok_pkg::VALUE_BITS{1'b1}}
                                        : acc_next[cotok_pkg::VALUE_BITS-1:0];
                end else begin
                    e0_v     = 1'b1;
                    e0.kind  = cotok_pkg::K_INT;
                    e0.len   = run_len;
                    e0.value = r_accum;
                    e0.ovf   = r_ovf;
                    n_mode   = cotok_pkg::MODE_IDLE;
                end
            end
            default: begin
            end
        endcase

        // byte starts something new
        if (!consumed) begin
            if (b == cotok_pkg::CH_END) begin
                e1_v         = 1'b1;
                e1.kind      = cotok_pkg::K_EOS;
                n_mode       = cotok_pkg::MODE_IDLE;
                n_pend       = '0;
                n_line       = LINE_ONE;
                n_pos        = '0;
                n_start_pos  = '0;
                n_start_line = LINE_ONE;
                n_accum      = '0;
                n_ovf        = 1'b0;
            end else begin
                n_start_pos  = r_pos;
                n_start_line = r_line;
                if (b == cotok_pkg::CH_NEWLINE) begin
                    if (r_line != LINE_MAX) begin
                        n_line = r_line + LINE_ONE;
                    end
                end else if (cotok_pkg::is_space(b)) begin
                    // skipped
                end else if (cotok_pkg::single_kind(b) != cotok_pkg::K_UNKNOWN) begin
                    e1_v    = 1'b1;
                    e1.kind = cotok_pkg::single_kind(b);
                end else if (cotok_pkg::op_alone(b) != cotok_pkg::K_UNKNOWN) begin
                    n_mode = cotok_pkg::MODE_OP;
                    n_pend = b;
                end else if (cotok_pkg::is_alpha(b) || b == cotok_pkg::CH_UNDERSCORE) begin
                    n_mode = cotok_pkg::MODE_IDENT;
                end else if (cotok_pkg::is_digit(b)) begin
                    n_mode  = cotok_pkg::MODE_NUM;
                    n_accum = cotok_pkg::VALUE_BITS'(b - cotok_pkg::CH_ZERO);
                    n_ovf   = 1'b0;
                end else begin
                    e1_v    = 1'b1;
                    e1.kind = cotok_pkg::K_UNKNOWN;
                end
            end
        end

        e0.last = !e1_v;
        e1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= cotok_pkg::MODE_IDLE;
            r_pend       <= '0;
            r_line       <= LINE_ONE;
            r_pos        <= '0;
            r_start_pos  <= '0;
            r_start_line <= LINE_ONE;
            r_accum      <= '0;
            r_ovf        <= 1'b0;
        end else if (in_acc) begin
            r_mode       <= n_mode;
            r_pend       <= n_pend;
            r_line       <= n_line;
            r_pos        <= n_pos;
            r_start_pos  <= n_start_pos;
            r_start_line <= n_start_line;
            r_accum      <= n_accum;
            r_ovf        <= n_ovf;
        end
    end

    // queue: up to two writes and up to one read per cycle
    assign wr_n = in_acc ? (2'(e0_v) + 2'(e1_v)) : 2'd0;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (e0_v) begin
                r_fifo[r_wr_ptr] <= e0;
                if (e1_v) begin
                    r_fifo[PTR_BITS'(r_wr_ptr + 1'b1)] <= e1;
                end
            end else if (e1_v) begin
                r_fifo[r_wr_ptr] <= e1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_BITS'(wr_n);
            r_rd_ptr <= r_rd_ptr + PTR_BITS'(out_acc);
            r_count  <= r_count + CNT_BITS'(wr_n) - CNT_BITS'(out_acc);
        end
    end

    assign head       = r_fifo[r_rd_ptr];
    assign o_s_tready = (r_count <= ROOM_MAX);
    assign o_m_tvalid = (r_count != '0);
    assign o_m_tdata  = DATA_BITS'({head.ovf, head.value, head.len, head.off, head.line});
    assign o_m_tuser  = head.kind;
    assign o_m_tlast  = head.last;

    // queue never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(cotok_pkg::FIFO_DEPTH))
        else $error("token queue overfilled");

    // end of stream restarts the lexer at offset 0, line 1
    a_eos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_s_tdata == cotok_pkg::CH_END)
        |=> (r_pos == '0) && (r_line == LINE_ONE) && (r_mode == cotok_pkg::MODE_IDLE))
        else $error("lexer not restarted after end of stream");

    // line counter never falls to zero
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0)
        else $error("line counter is zero");

    // a byte that yields two tokens leaves at least two words queued
    a_queue_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (wr_n == 2'd2) |=> (r_count >= CNT_BITS'(2)))
        else $error("two-token write lost");

endmodule
